>>> hdl/sdi_pkg.sv
// shared codes and constants for the degenerate string stream indexer
`default_nettype none

package sdi_pkg;

  // delimiter characters
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // record kinds
  localparam logic [1:0] REC_STRING = 2'd0;
  localparam logic [1:0] REC_SET    = 2'd1;
  localparam logic [1:0] REC_STAT   = 2'd2;

  // statistic indexes
  localparam logic [3:0] ST_VAR_CHARS = 4'd0;
  localparam logic [3:0] ST_COM_COUNT = 4'd1;
  localparam logic [3:0] ST_COM_LEN   = 4'd2;
  localparam logic [3:0] ST_SETS      = 4'd3;
  localparam logic [3:0] ST_CHARS     = 4'd4;
  localparam logic [3:0] ST_STRINGS   = 4'd5;
  localparam logic [3:0] ST_SHORTEST  = 4'd6;
  localparam logic [3:0] ST_LONGEST   = 4'd7;
  localparam logic [3:0] ST_AVG       = 4'd8;
  localparam logic [3:0] ST_EMPTY     = 4'd9;
  localparam logic [3:0] ST_LAST      = ST_EMPTY;

  localparam logic [15:0] MEMBERS_MAX = 16'hFFFF;
  localparam logic [30:0] VARIANT_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] VARIANT_COMMON = -32'sd1;

  // what the delimiter of the current request asks for
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_COMMA = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_STR    = 6'b000010,
    S_SET    = 6'b000100,
    S_DSTART = 6'b001000,
    S_DWAIT  = 6'b010000,
    S_STAT   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

>>> hdl/sdi_if.sv
// valid/ready channels for the symbol stream and the record stream
`default_nettype none

interface sdi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source(output valid, symbol, end_of_text, input ready);
  modport sink(input valid, symbol, end_of_text, output ready);
endinterface

interface sdi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic [31:0]        string_length;
  logic [31:0]        file_offset;
  logic [31:0]        reference_offset;
  logic signed [31:0] variant_number;
  logic               is_common;
  logic [15:0]        set_members;
  logic [31:0]        cumulative_members;
  logic [3:0]         stat_index;
  logic [31:0]        stat_value;
  logic               last_of_run;

  modport source(output valid, record_kind, string_length, file_offset, reference_offset,
                 variant_number, is_common, set_members, cumulative_members, stat_index,
                 stat_value, last_of_run, input ready);
  modport sink(input valid, record_kind, string_length, file_offset, reference_offset,
               variant_number, is_common, set_members, cumulative_members, stat_index,
               stat_value, last_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/sdi_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module sdi_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             zero_r, zero_nxt;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[W-1]};
    diff     = shifted - {1'b0, div_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      zero_nxt = (divisor == '0);
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  // a zero count averages to zero
  assign quotient = zero_r ? '0 : quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

>>> hdl/degenerate_string_stream_indexer_core.sv
// top level: elastic-degenerate text parser with string, set and statistic records
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------------
//  in_ch    | in  | valid/ready      | symbol, end_of_text
//  out_ch   | out | valid/ready      | record_kind and string/set/statistic fields
//
// a plain character, newline or bare open brace is taken in S_IDLE; a comma then
// emits a string record from S_STR, a close brace or an open brace after pending
// text a string record from S_STR and then a set record from S_SET
// end of text: accepted in S_IDLE, pending text flushed through S_STR and S_SET,
// then the average from the bit-serial divider, then ten statistic records
// ready is high only while the sequencer is idle; each record waits in the output
// register while the sink stalls; synchronous active-low reset clears all counters
`default_nettype none

module degenerate_string_stream_indexer_core #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sdi_in_if.sink    in_ch,
  sdi_out_if.source out_ch
);

  import sdi_pkg::*;

  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CNT_ONE = {{(CW-1){1'b0}}, 1'b1};

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [CW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  state_t        state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [CW-1:0] cur_len_r, cur_len_nxt;
  logic [CW-1:0] char_pos_r, char_pos_nxt;
  logic [15:0]   members_r, members_nxt;
  logic [30:0]   var_cnt_r, var_cnt_nxt;
  logic [CW-1:0] set_cnt_r, set_cnt_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] str_cnt_r, str_cnt_nxt;
  logic [CW-1:0] com_cnt_r, com_cnt_nxt;
  logic [CW-1:0] com_len_r, com_len_nxt;
  logic [CW-1:0] short_r, short_nxt;
  logic [CW-1:0] long_r, long_nxt;
  logic [CW-1:0] empty_r, empty_nxt;
  logic [CW-1:0] var_chars_r, var_chars_nxt;
  logic [CW-1:0] cum_r, cum_nxt;
  logic [15:0]   set_mem_r, set_mem_nxt;
  logic [3:0]    stat_idx_r, stat_idx_nxt;

  logic               o_valid_r, o_valid_nxt;
  logic [1:0]         o_kind_r, o_kind_nxt;
  logic [31:0]        o_len_r, o_len_nxt;
  logic [31:0]        o_foff_r, o_foff_nxt;
  logic [31:0]        o_roff_r, o_roff_nxt;
  logic signed [31:0] o_var_r, o_var_nxt;
  logic               o_com_r, o_com_nxt;
  logic [15:0]        o_smem_r, o_smem_nxt;
  logic [31:0]        o_cum_r, o_cum_nxt;
  logic [3:0]         o_sidx_r, o_sidx_nxt;
  logic [31:0]        o_sval_r, o_sval_nxt;
  logic               o_last_r, o_last_nxt;

  logic          in_acc;
  logic          out_free;
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_q;

  sdi_div #(.W(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (com_len_r),
    .divisor  (com_cnt_r),
    .quotient (div_q),
    .done     (div_done)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !o_valid_r || out_ch.ready;

  always_comb begin
    logic          common;
    logic [CW-1:0] set_tmp;
    logic [CW-1:0] stat_v;

    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_len_nxt   = cur_len_r;
    char_pos_nxt  = char_pos_r;
    members_nxt   = members_r;
    var_cnt_nxt   = var_cnt_r;
    set_cnt_nxt   = set_cnt_r;
    total_nxt     = total_r;
    str_cnt_nxt   = str_cnt_r;
    com_cnt_nxt   = com_cnt_r;
    com_len_nxt   = com_len_r;
    short_nxt     = short_r;
    long_nxt      = long_r;
    empty_nxt     = empty_r;
    var_chars_nxt = var_chars_r;
    cum_nxt       = cum_r;
    set_mem_nxt   = set_mem_r;
    stat_idx_nxt  = stat_idx_r;
    div_start     = 1'b0;
    common        = 1'b0;
    set_tmp       = set_cnt_r;
    stat_v        = '0;

    o_valid_nxt = o_valid_r && !out_ch.ready;
    o_kind_nxt  = o_kind_r;
    o_len_nxt   = o_len_r;
    o_foff_nxt  = o_foff_r;
    o_roff_nxt  = o_roff_r;
    o_var_nxt   = o_var_r;
    o_com_nxt   = o_com_r;
    o_smem_nxt  = o_smem_r;
    o_cum_nxt   = o_cum_r;
    o_sidx_nxt  = o_sidx_r;
    o_sval_nxt  = o_sval_r;
    o_last_nxt  = o_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.end_of_text) begin
            op_nxt    = OP_END;
            state_nxt = (cur_len_r != '0) ? S_STR : S_DSTART;
          end else begin
            case (in_ch.symbol)
              CH_OPEN: begin
                op_nxt = OP_OPEN;
                if (cur_len_r != '0) begin
                  state_nxt = S_STR;
                end else begin
                  members_nxt  = 16'd1;
                  set_cnt_nxt  = sat_add(set_cnt_r, CNT_ONE);
                  char_pos_nxt = sat_add(char_pos_r, CNT_ONE);
                end
              end
              CH_CLOSE: begin
                op_nxt    = OP_CLOSE;
                state_nxt = S_STR;
              end
              CH_COMMA: begin
                op_nxt    = OP_COMMA;
                state_nxt = S_STR;
              end
              CH_NL: begin
                char_pos_nxt = sat_add(char_pos_r, CNT_ONE);
              end
              default: begin
                cur_len_nxt  = sat_add(cur_len_r, CNT_ONE);
                char_pos_nxt = sat_add(char_pos_r, CNT_ONE);
              end
            endcase
          end
        end
      end

      S_STR: begin
        if (out_free) begin
          // pending text before an open brace or at the end is a common string
          if (op_r == OP_OPEN || op_r == OP_END) begin
            common = 1'b1;
          end else if (op_r == OP_CLOSE) begin
            common = (members_r == 16'd1);
          end
          o_valid_nxt = 1'b1;
          o_kind_nxt  = REC_STRING;
          o_len_nxt   = to32(cur_len_r);
          o_foff_nxt  = to32((char_pos_r >= cur_len_r) ? (char_pos_r - cur_len_r) : '0);
          o_roff_nxt  = to32(com_len_r);
          o_var_nxt   = common ? VARIANT_COMMON : $signed({1'b0, var_cnt_r});
          o_com_nxt   = common;
          o_smem_nxt  = '0;
          o_cum_nxt   = '0;
          o_sidx_nxt  = '0;
          o_sval_nxt  = '0;
          o_last_nxt  = (op_r == OP_COMMA);

          if (common) begin
            com_cnt_nxt = sat_add(com_cnt_r, CNT_ONE);
            com_len_nxt = sat_add(com_len_r, cur_len_r);
            if (cur_len_r > long_r) long_nxt = cur_len_r;
            if (cur_len_r < short_r) short_nxt = cur_len_r;
          end else begin
            var_chars_nxt = sat_add(var_chars_r, cur_len_r);
            if (var_cnt_r != VARIANT_MAX) var_cnt_nxt = var_cnt_r + 31'd1;
          end
          if ((op_r == OP_CLOSE || op_r == OP_COMMA) && cur_len_r == '0) begin
            empty_nxt = sat_add(empty_r, CNT_ONE);
          end
          total_nxt   = sat_add(total_r, cur_len_r);
          cur_len_nxt = '0;

          case (op_r)
            OP_COMMA: begin
              if (members_r != MEMBERS_MAX) members_nxt = members_r + 16'd1;
              char_pos_nxt = sat_add(char_pos_r, CNT_ONE);
              state_nxt    = S_IDLE;
            end
            OP_CLOSE: begin
              str_cnt_nxt = sat_add(str_cnt_r, CW'(members_r));
              set_mem_nxt = members_r;
              state_nxt   = S_SET;
            end
            default: begin
              str_cnt_nxt = sat_add(str_cnt_r, CNT_ONE);
              set_mem_nxt = 16'd1;
              state_nxt   = S_SET;
            end
          endcase
        end
      end

      S_SET: begin
        if (out_free) begin
          cum_nxt     = sat_add(cum_r, CW'(set_mem_r));
          o_valid_nxt = 1'b1;
          o_kind_nxt  = REC_SET;
          o_len_nxt   = '0;
          o_foff_nxt  = '0;
          o_roff_nxt  = '0;
          o_var_nxt   = '0;
          o_com_nxt   = 1'b0;
          o_smem_nxt  = set_mem_r;
          o_cum_nxt   = to32(cum_nxt);
          o_sidx_nxt  = '0;
          o_sval_nxt  = '0;
          o_last_nxt  = (op_r != OP_END);

          // a flushed common string counts as a set of its own
          if (op_r != OP_CLOSE) set_tmp = sat_add(set_cnt_r, CNT_ONE);
          if (op_r == OP_OPEN) begin
            set_tmp     = sat_add(set_tmp, CNT_ONE);
            members_nxt = 16'd1;
          end
          set_cnt_nxt = set_tmp;

          if (op_r == OP_END) begin
            state_nxt = S_DSTART;
          end else begin
            char_pos_nxt = sat_add(char_pos_r, CNT_ONE);
            state_nxt    = S_IDLE;
          end
        end
      end

      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_done) begin
          stat_idx_nxt = ST_VAR_CHARS;
          state_nxt    = S_STAT;
        end
      end

      S_STAT: begin
        case (stat_idx_r)
          ST_VAR_CHARS: stat_v = var_chars_r;
          ST_COM_COUNT: stat_v = com_cnt_r;
          ST_COM_LEN:   stat_v = com_len_r;
          ST_SETS:      stat_v = set_cnt_r;
          ST_CHARS:     stat_v = total_r;
          ST_STRINGS:   stat_v = str_cnt_r;
          ST_SHORTEST:  stat_v = (short_r < char_pos_r) ? short_r : char_pos_r;
          ST_LONGEST:   stat_v = long_r;
          ST_AVG:       stat_v = div_q;
          ST_EMPTY:     stat_v = empty_r;
          default:      stat_v = '0;
        endcase
        if (out_free) begin
          o_valid_nxt = 1'b1;
          o_kind_nxt  = REC_STAT;
          o_len_nxt   = '0;
          o_foff_nxt  = '0;
          o_roff_nxt  = '0;
          o_var_nxt   = '0;
          o_com_nxt   = 1'b0;
          o_smem_nxt  = '0;
          o_cum_nxt   = '0;
          o_sidx_nxt  = stat_idx_r;
          o_sval_nxt  = to32(stat_v);
          o_last_nxt  = (stat_idx_r == ST_LAST);
          if (stat_idx_r == ST_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            stat_idx_nxt = stat_idx_r + 4'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_OPEN;
      cur_len_r   <= '0;
      char_pos_r  <= '0;
      members_r   <= '0;
      var_cnt_r   <= '0;
      set_cnt_r   <= '0;
      total_r     <= '0;
      str_cnt_r   <= '0;
      com_cnt_r   <= '0;
      com_len_r   <= '0;
      short_r     <= '1;
      long_r      <= '0;
      empty_r     <= '0;
      var_chars_r <= '0;
      cum_r       <= '0;
      set_mem_r   <= '0;
      stat_idx_r  <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cur_len_r   <= cur_len_nxt;
      char_pos_r  <= char_pos_nxt;
      members_r   <= members_nxt;
      var_cnt_r   <= var_cnt_nxt;
      set_cnt_r   <= set_cnt_nxt;
      total_r     <= total_nxt;
      str_cnt_r   <= str_cnt_nxt;
      com_cnt_r   <= com_cnt_nxt;
      com_len_r   <= com_len_nxt;
      short_r     <= short_nxt;
      long_r      <= long_nxt;
      empty_r     <= empty_nxt;
      var_chars_r <= var_chars_nxt;
      cum_r       <= cum_nxt;
      set_mem_r   <= set_mem_nxt;
      stat_idx_r  <= stat_idx_nxt;
      o_valid_r   <= o_valid_nxt;
    end
    o_kind_r <= o_kind_nxt;
    o_len_r  <= o_len_nxt;
    o_foff_r <= o_foff_nxt;
    o_roff_r <= o_roff_nxt;
    o_var_r  <= o_var_nxt;
    o_com_r  <= o_com_nxt;
    o_smem_r <= o_smem_nxt;
    o_cum_r  <= o_cum_nxt;
    o_sidx_r <= o_sidx_nxt;
    o_sval_r <= o_sval_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = o_valid_r;
  assign out_ch.record_kind        = o_kind_r;
  assign out_ch.string_length      = o_len_r;
  assign out_ch.file_offset        = o_foff_r;
  assign out_ch.reference_offset   = o_roff_r;
  assign out_ch.variant_number     = o_var_r;
  assign out_ch.is_common          = o_com_r;
  assign out_ch.set_members        = o_smem_r;
  assign out_ch.cumulative_members = o_cum_r;
  assign out_ch.stat_index         = o_sidx_r;
  assign out_ch.stat_value         = o_sval_r;
  assign out_ch.last_of_run        = o_last_r;

endmodule

`default_nettype wire

>>> hdl/sdi_chk.sv
// port-level checks on the indexer, bound to the top level
`default_nettype none

module sdi_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [3:0] out_stat_index,
  input wire logic       out_last
);

  import sdi_pkg::*;

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("record changed while stalled");

  // no new request while the current one still has records to come
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request accepted in the middle of a run");

  // statistics go out back to back in index order
  a_stat_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == REC_STAT && !out_last |=>
      out_valid && out_kind == REC_STAT && out_stat_index == $past(out_stat_index) + 4'd1)
    else $error("statistic out of order");

  // the run of statistics ends exactly at the last index
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == REC_STAT |-> out_last == (out_stat_index == ST_LAST))
    else $error("last flag wrong on statistic");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("record valid after reset");

endmodule

bind degenerate_string_stream_indexer_core sdi_chk u_sdi_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.record_kind),
  .out_stat_index (out_ch.stat_index),
  .out_last       (out_ch.last_of_run)
);

`default_nettype wire

>>> verif/degenerate_string_stream_indexer_core_tb.sv
// self-checking testbench for the degenerate string stream indexer core
`timescale 1ns / 1ps

module degenerate_string_stream_indexer_core_tb;
  import sdi_pkg::*;

  localparam int CNT_W        = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SHOW_MAX     = 10;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        len;
    logic [31:0]        foff;
    logic [31:0]        roff;
    logic signed [31:0] vnum;
    logic               com;
    logic [15:0]        members;
    logic [31:0]        cum;
    logic [3:0]         sidx;
    logic [31:0]        sval;
    logic               last;
  } rec_t;

  logic clk;
  logic rst_n;

  sdi_in_if  in_ch();
  sdi_out_if out_ch();

  degenerate_string_stream_indexer_core #(
    .COUNT_BITS(CNT_W)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  int   snd_idle;
  int   rcv_idle;
  int   sent;
  int   errors;
  int   cycles;
  rec_t records_due[$];
  rec_t got_rec;
  rec_t want_rec;

  // parser state of the predictor
  logic [CNT_W-1:0] run_len, pos, var_idx, sets, chars, strings;
  logic [CNT_W-1:0] com_cnt, com_len, com_min, com_max, empties, var_chars, cum_members;
  logic [15:0]      mset;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic string rec_str(rec_t r);
    return $sformatf({"kind=%0d len=%0d foff=%0d roff=%0d var=%0d com=%0b mem=%0d cum=%0d ",
                      "idx=%0d val=%0d last=%0b"}, r.kind, r.len, r.foff, r.roff, r.vnum,
                     r.com, r.members, r.cum, r.sidx, r.sval, r.last);
  endfunction

  task automatic clear_model();
    run_len = '0; pos = '0; mset = '0; var_idx = '0; sets = '0; chars = '0;
    strings = '0; com_cnt = '0; com_len = '0; com_min = '1; com_max = '0;
    empties = '0; var_chars = '0; cum_members = '0;
  endtask

  task automatic push_string(bit common);
    rec_t r;
    r = '0;
    r.kind = REC_STRING;
    r.len  = run_len;
    r.foff = (pos >= run_len) ? pos - run_len : '0;
    r.roff = com_len;
    r.vnum = common ? VARIANT_COMMON : var_idx;
    r.com  = common;
    records_due = {records_due, r};
  endtask

  task automatic push_set(logic [15:0] members);
    rec_t r;
    cum_members = sat_add(cum_members, CNT_W'(members));
    r = '0;
    r.kind    = REC_SET;
    r.members = members;
    r.cum     = cum_members;
    records_due = {records_due, r};
  endtask

  task automatic push_stat(logic [3:0] idx, logic [CNT_W-1:0] val);
    rec_t r;
    r = '0;
    r.kind = REC_STAT;
    r.sidx = idx;
    r.sval = val;
    records_due = {records_due, r};
  endtask

  task automatic note_common();
    com_cnt = sat_add(com_cnt, 1);
    com_len = sat_add(com_len, run_len);
    if (run_len > com_max) com_max = run_len;
    if (run_len < com_min) com_min = run_len;
  endtask

  task automatic note_variant();
    var_chars = sat_add(var_chars, run_len);
    if (var_idx < {1'b0, VARIANT_MAX}) var_idx = var_idx + 1;
  endtask

  // text pending outside braces closes as a common one-member set
  task automatic flush_common();
    push_string(1'b1);
    note_common();
    push_set(16'd1);
    sets    = sat_add(sets, 1);
    strings = sat_add(strings, 1);
    chars   = sat_add(chars, run_len);
    run_len = '0;
  endtask

  task automatic index_symbol(logic [7:0] sym, logic eot);
    int   n_due;
    bit   common;
    n_due = records_due.size();
    if (eot) begin
      if (run_len != 0) flush_common();
      push_stat(ST_VAR_CHARS, var_chars);
      push_stat(ST_COM_COUNT, com_cnt);
      push_stat(ST_COM_LEN, com_len);
      push_stat(ST_SETS, sets);
      push_stat(ST_CHARS, chars);
      push_stat(ST_STRINGS, strings);
      push_stat(ST_SHORTEST, (com_min < pos) ? com_min : pos);
      push_stat(ST_LONGEST, com_max);
      push_stat(ST_AVG, (com_cnt != 0) ? com_len / com_cnt : '0);
      push_stat(ST_EMPTY, empties);
    end else begin
      case (sym)
        CH_OPEN: begin
          if (run_len != 0) flush_common();
          mset = 16'd1;
          sets = sat_add(sets, 1);
        end
        CH_CLOSE: begin
          common = (mset == 16'd1);
          push_string(common);
          if (run_len == 0) empties = sat_add(empties, 1);
          if (common) note_common();
          else note_variant();
          push_set(mset);
          strings = sat_add(strings, CNT_W'(mset));
          chars   = sat_add(chars, run_len);
          run_len = '0;
        end
        CH_COMMA: begin
          push_string(1'b0);
          note_variant();
          if (run_len == 0) empties = sat_add(empties, 1);
          if (mset < MEMBERS_MAX) mset = mset + 16'd1;
          chars   = sat_add(chars, run_len);
          run_len = '0;
        end
        CH_NL: ;
        default: run_len = sat_add(run_len, 1);
      endcase
      pos = sat_add(pos, 1);
    end
    if (records_due.size() > n_due) begin
      records_due[records_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic note_bad(string what, rec_t want, rec_t got, bit has_want);
    errors++;
    if (errors <= SHOW_MAX) begin
      $display("%s at cycle %0d", what, cycles);
      if (has_want) $display("  expected %s", rec_str(want));
      $display("  actual   %s", rec_str(got));
    end
  endtask

  task automatic send_item(logic [7:0] sym, logic eot);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    index_symbol(sym, eot);
    sent++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return CH_NL;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_OPEN || b == CH_CLOSE || b == CH_COMMA || b == CH_NL);
    return b;
  endfunction

  // mostly well-formed common runs and variant sets, with some stray bytes and ends of text
  task automatic run_random(int target, int noise_pct);
    int stop;
    int roll;
    int alts;
    int i;
    stop = sent + target;
    while (sent < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        case ($urandom_range(0, 5))
          0: send_item(CH_CLOSE, 1'b0);
          1: send_item(CH_COMMA, 1'b0);
          2: send_item(CH_OPEN, 1'b0);
          3: send_item(CH_NL, 1'b0);
          default: send_item(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end else if (roll < noise_pct + 4) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(0, 4)) send_item(text_byte(), 1'b0);
        if ($urandom_range(0, 3) != 0) begin
          send_item(CH_OPEN, 1'b0);
          alts = $urandom_range(1, 4);
          for (i = 0; i < alts; i++) begin
            if (i > 0) send_item(CH_COMMA, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(text_byte(), 1'b0);
          end
          send_item(CH_CLOSE, 1'b0);
        end
      end
    end
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b1);        // statistics of an empty text
    send_item(CH_CLOSE, 1'b0);     // close with no set open, zero members
    send_item(CH_COMMA, 1'b0);     // stray comma
    send_item(8'h61, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item(CH_OPEN, 1'b0);      // open brace flushes pending text
    send_item(8'h78, 1'b0);
    send_item(CH_CLOSE, 1'b0);     // single member set is common
    send_item(CH_OPEN, 1'b0);
    send_item(CH_COMMA, 1'b0);     // empty alternative
    send_item(8'h62, 1'b0);
    send_item(CH_COMMA, 1'b0);
    send_item(CH_CLOSE, 1'b0);     // empty last alternative
    send_item(8'h00, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item(8'hFF, 1'b1);        // flush trailing common text
    send_item(8'h7B, 1'b1);        // repeated end of text, symbol ignored
    send_item(CH_OPEN, 1'b0);
    send_item(CH_CLOSE, 1'b0);     // empty common
    send_item(CH_COMMA, 1'b0);     // continues from the last set's members
    send_item(CH_CLOSE, 1'b0);
    send_item(8'h7A, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_wellformed();
    run_random(100, 5);
  endtask

  task automatic test_noisy();
    run_random(100, 30);
  endtask

  task automatic test_steady();
    run_random(95, 10);
    send_item(8'h00, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d records outstanding", records_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_rec.kind    = out_ch.record_kind;
      got_rec.len     = out_ch.string_length;
      got_rec.foff    = out_ch.file_offset;
      got_rec.roff    = out_ch.reference_offset;
      got_rec.vnum    = out_ch.variant_number;
      got_rec.com     = out_ch.is_common;
      got_rec.members = out_ch.set_members;
      got_rec.cum     = out_ch.cumulative_members;
      got_rec.sidx    = out_ch.stat_index;
      got_rec.sval    = out_ch.stat_value;
      got_rec.last    = out_ch.last_of_run;
      if (records_due.size() == 0) begin
        note_bad("unexpected record", '0, got_rec, 1'b0);
      end else begin
        want_rec = records_due.pop_front();
        if (got_rec !== want_rec) note_bad("record mismatch", want_rec, got_rec, 1'b1);
      end
    end
  end

  initial begin
    cycles            = 0;
    errors            = 0;
    sent              = 0;
    snd_idle          = 29;
    rcv_idle          = 69;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.symbol      = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    clear_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_wellformed();
    snd_idle = 69;
    rcv_idle = 29;
    test_noisy();
    snd_idle = 0;
    rcv_idle = 0;
    test_steady();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (records_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && records_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sdi_pkg.sv
hdl/sdi_if.sv
hdl/sdi_div.sv
hdl/degenerate_string_stream_indexer_core.sv
hdl/sdi_chk.sv
verif/degenerate_string_stream_indexer_core_tb.sv
